>>> rtl/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg: shared constants and width helpers
// Field widths, fixed-point constants and the queue item layout size for the
// contact impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int VEL_WIDTH_DEF   = 32;
  localparam int NORM_W          = 16;
  localparam int MASS_W          = 32;
  localparam int REST_W          = 16;
  localparam int TOTAL_W         = MASS_W + 1;
  localparam int COEF_W          = REST_W + 1;
  localparam int K_W             = COEF_W + NORM_W;
  localparam int CHUNK_W         = 32;
  localparam int ROUND_SHIFT     = 43;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [REST_W-1:0] REST_RESET = 16'd32768;
  localparam logic [COEF_W-1:0] COEF_ONE   = 17'd32768;

  // relative velocity width, saturated to 64 bits
  function automatic int rel_w(input int vw);
    return (vw < 64) ? vw + 1 : 64;
  endfunction

  // width of the signed separating velocity sum
  function automatic int sum_w(input int vw);
    return rel_w(vw) + NORM_W + 1;
  endfunction

  // go, second present, four velocities, normal, two masses, sum, total
  function automatic int item_w(input int vw);
    return 2 + 4 * vw + 2 * NORM_W + 2 * MASS_W + sum_w(vw) + TOTAL_W;
  endfunction

endpackage

>>> rtl/cir_queue.sv
// ----------------------------------------------------------------------------
// cir_queue: contact queue
// Small register queue between the front and the back of the resolver.
// ----------------------------------------------------------------------------
module cir_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 push_data,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 pop_data,
  output logic [$clog2(DEPTH+1)-1:0]       count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data = slots[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CNT_W'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

endmodule

>>> rtl/cir_front.sv
// ----------------------------------------------------------------------------
// cir_front: contact classifier
// Registers a contact, forms the relative velocity and the separating
// velocity along the normal, and decides whether an impulse applies.
// ----------------------------------------------------------------------------
module cir_front #(
  parameter int VEL_WIDTH = cir_pkg::VEL_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic                                   first_present,
  input  logic                                   second_present,
  input  logic signed [VEL_WIDTH-1:0]            first_vel_x,
  input  logic signed [VEL_WIDTH-1:0]            first_vel_y,
  input  logic signed [VEL_WIDTH-1:0]            second_vel_x,
  input  logic signed [VEL_WIDTH-1:0]            second_vel_y,
  input  logic signed [cir_pkg::NORM_W-1:0]      normal_x,
  input  logic signed [cir_pkg::NORM_W-1:0]      normal_y,
  input  logic [cir_pkg::MASS_W-1:0]             first_inv_mass,
  input  logic [cir_pkg::MASS_W-1:0]             second_inv_mass,
  output logic                                   push,
  output logic [cir_pkg::item_w(VEL_WIDTH)-1:0]  item,
  output logic [1:0]                             inflight
);
  import cir_pkg::*;

  localparam int VW = VEL_WIDTH;
  localparam int RW = rel_w(VW);
  localparam int PW = RW + NORM_W;
  localparam int SW = sum_w(VW);

  logic signed [VW-1:0] v2x_eff;
  logic signed [VW-1:0] v2y_eff;
  logic signed [VW:0]   diff_x;
  logic signed [VW:0]   diff_y;
  logic signed [RW-1:0] rel_x;
  logic signed [RW-1:0] rel_y;

  assign v2x_eff = second_present ? second_vel_x : '0;
  assign v2y_eff = second_present ? second_vel_y : '0;
  assign diff_x  = {first_vel_x[VW-1], first_vel_x} - {v2x_eff[VW-1], v2x_eff};
  assign diff_y  = {first_vel_y[VW-1], first_vel_y} - {v2y_eff[VW-1], v2y_eff};

  if (RW == VW + 1) begin : g_rel_exact
    assign rel_x = diff_x;
    assign rel_y = diff_y;
  end else begin : g_rel_sat
    assign rel_x = (diff_x[VW] != diff_x[VW-1]) ?
                   {diff_x[VW], {(RW-1){~diff_x[VW]}}} : diff_x[RW-1:0];
    assign rel_y = (diff_y[VW] != diff_y[VW-1]) ?
                   {diff_y[VW], {(RW-1){~diff_y[VW]}}} : diff_y[RW-1:0];
  end

  // stage 1
  logic                     f1_v;
  logic                     f1_p1;
  logic                     f1_p2;
  logic [VW-1:0]            f1_v1x, f1_v1y, f1_v2x, f1_v2y;
  logic signed [NORM_W-1:0] f1_nx, f1_ny;
  logic [MASS_W-1:0]        f1_m1, f1_m2;
  logic signed [RW-1:0]     f1_rel_x, f1_rel_y;

  // stage 2
  logic                     f2_v;
  logic                     f2_p1;
  logic                     f2_p2;
  logic [VW-1:0]            f2_v1x, f2_v1y, f2_v2x, f2_v2y;
  logic [NORM_W-1:0]        f2_nx, f2_ny;
  logic [MASS_W-1:0]        f2_m1, f2_m2;
  logic signed [PW-1:0]     f2_prod_x, f2_prod_y;
  logic [TOTAL_W-1:0]       f2_total;

  // stage 3
  logic                     f3_v;
  logic                     f3_go;
  logic                     f3_p2;
  logic [VW-1:0]            f3_v1x, f3_v1y, f3_v2x, f3_v2y;
  logic [NORM_W-1:0]        f3_nx, f3_ny;
  logic [MASS_W-1:0]        f3_m1, f3_m2;
  logic [SW-1:0]            f3_sum;
  logic [TOTAL_W-1:0]       f3_total;

  logic [SW-1:0]            sep_sum;

  assign sep_sum = {f2_prod_x[PW-1], f2_prod_x} + {f2_prod_y[PW-1], f2_prod_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else begin
      f1_v <= accept;
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    f1_p1    <= first_present;
    f1_p2    <= second_present;
    f1_v1x   <= first_vel_x;
    f1_v1y   <= first_vel_y;
    f1_v2x   <= second_vel_x;
    f1_v2y   <= second_vel_y;
    f1_nx    <= normal_x;
    f1_ny    <= normal_y;
    f1_m1    <= first_inv_mass;
    f1_m2    <= second_present ? second_inv_mass : '0;
    f1_rel_x <= rel_x;
    f1_rel_y <= rel_y;

    f2_p1     <= f1_p1;
    f2_p2     <= f1_p2;
    f2_v1x    <= f1_v1x;
    f2_v1y    <= f1_v1y;
    f2_v2x    <= f1_v2x;
    f2_v2y    <= f1_v2y;
    f2_nx     <= f1_nx;
    f2_ny     <= f1_ny;
    f2_m1     <= f1_m1;
    f2_m2     <= f1_m2;
    f2_prod_x <= f1_rel_x * f1_nx;
    f2_prod_y <= f1_rel_y * f1_ny;
    f2_total  <= {1'b0, f1_m1} + {1'b0, f1_m2};

    f3_go    <= f2_p1 && sep_sum[SW-1] && (f2_total != '0);
    f3_p2    <= f2_p2;
    f3_v1x   <= f2_v1x;
    f3_v1y   <= f2_v1y;
    f3_v2x   <= f2_v2x;
    f3_v2y   <= f2_v2y;
    f3_nx    <= f2_nx;
    f3_ny    <= f2_ny;
    f3_m1    <= f2_m1;
    f3_m2    <= f2_m2;
    f3_sum   <= sep_sum;
    f3_total <= f2_total;
  end

  assign push     = f3_v;
  assign item     = {f3_go, f3_p2, f3_v1x, f3_v1y, f3_v2x, f3_v2y, f3_nx, f3_ny,
                     f3_m1, f3_m2, f3_sum, f3_total};
  assign inflight = 2'(f1_v) + 2'(f2_v) + 2'(f3_v);

endmodule

>>> rtl/cir_divider.sv
// ----------------------------------------------------------------------------
// cir_divider: pipelined restoring divider
// Two numerators over one shared divisor, one quotient bit per stage, with
// side data carried in step.
// ----------------------------------------------------------------------------
module cir_divider #(
  parameter int QW     = 50,
  parameter int DW     = 33,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [QW+DW-2:0]     num_a,
  input  logic [QW+DW-2:0]     num_b,
  input  logic [DW-1:0]        den,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [QW-1:0]        q_a,
  output logic [QW-1:0]        q_b,
  output logic [SIDE_W-1:0]    side_out
);
  logic              vld      [QW];
  logic [DW-1:0]     rem_a    [QW];
  logic [DW-1:0]     rem_b    [QW];
  logic [QW-1:0]     lo_a     [QW];
  logic [QW-1:0]     lo_b     [QW];
  logic [DW-1:0]     dvs      [QW];
  logic [SIDE_W-1:0] side     [QW];

  logic              cur_v    [QW];
  logic [DW-1:0]     cur_ra   [QW];
  logic [DW-1:0]     cur_rb   [QW];
  logic [QW-1:0]     cur_la   [QW];
  logic [QW-1:0]     cur_lb   [QW];
  logic [DW-1:0]     cur_den  [QW];
  logic [SIDE_W-1:0] cur_side [QW];
  logic [DW-1:0]     rem_a_next [QW];
  logic [DW-1:0]     rem_b_next [QW];
  logic [QW-1:0]     lo_a_next  [QW];
  logic [QW-1:0]     lo_b_next  [QW];

  always_comb begin
    logic [DW:0] ta;
    logic [DW:0] tb;
    logic [DW:0] da;
    logic [DW:0] db;
    logic        ge_a;
    logic        ge_b;
    cur_v[0]    = in_valid;
    cur_ra[0]   = {1'b0, num_a[QW+DW-2:QW]};
    cur_rb[0]   = {1'b0, num_b[QW+DW-2:QW]};
    cur_la[0]   = num_a[QW-1:0];
    cur_lb[0]   = num_b[QW-1:0];
    cur_den[0]  = den;
    cur_side[0] = side_in;
    for (int i = 1; i < QW; i++) begin
      cur_v[i]    = vld[i-1];
      cur_ra[i]   = rem_a[i-1];
      cur_rb[i]   = rem_b[i-1];
      cur_la[i]   = lo_a[i-1];
      cur_lb[i]   = lo_b[i-1];
      cur_den[i]  = dvs[i-1];
      cur_side[i] = side[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      ta   = {cur_ra[i], cur_la[i][QW-1]};
      tb   = {cur_rb[i], cur_lb[i][QW-1]};
      da   = ta - {1'b0, cur_den[i]};
      db   = tb - {1'b0, cur_den[i]};
      ge_a = ta >= {1'b0, cur_den[i]};
      ge_b = tb >= {1'b0, cur_den[i]};
      rem_a_next[i] = ge_a ? da[DW-1:0] : ta[DW-1:0];
      rem_b_next[i] = ge_b ? db[DW-1:0] : tb[DW-1:0];
      lo_a_next[i]  = {cur_la[i][QW-2:0], ge_a};
      lo_b_next[i]  = {cur_lb[i][QW-2:0], ge_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < QW; i++) begin
        vld[i] <= cur_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_a[i] <= rem_a_next[i];
        rem_b[i] <= rem_b_next[i];
        lo_a[i]  <= lo_a_next[i];
        lo_b[i]  <= lo_b_next[i];
        dvs[i]   <= cur_den[i];
        side[i]  <= cur_side[i];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign q_a       = lo_a[QW-1];
  assign q_b       = lo_b[QW-1];
  assign side_out  = side[QW-1];

endmodule

>>> rtl/cir_back.sv
// ----------------------------------------------------------------------------
// cir_back: impulse execution pipeline
// Scales the separating velocity by each inverse mass, divides by the total,
// applies restitution and the normal, and updates the saturated velocities.
// ----------------------------------------------------------------------------
module cir_back #(
  parameter int VEL_WIDTH = cir_pkg::VEL_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_avail,
  input  logic [cir_pkg::item_w(VEL_WIDTH)-1:0]  q_data,
  output logic                                   q_pop,
  input  logic [cir_pkg::REST_W-1:0]             rest_coef,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [VEL_WIDTH-1:0]            new_first_vel_x,
  output logic signed [VEL_WIDTH-1:0]            new_first_vel_y,
  output logic signed [VEL_WIDTH-1:0]            new_second_vel_x,
  output logic signed [VEL_WIDTH-1:0]            new_second_vel_y,
  output logic                                   impulse_applied,
  output logic                                   saturated
);
  import cir_pkg::*;

  localparam int VW     = VEL_WIDTH;
  localparam int SW     = sum_w(VW);
  localparam int NC     = (SW + CHUNK_W - 1) / CHUNK_W;
  localparam int PADW   = NC * CHUNK_W;
  localparam int NW     = SW + MASS_W;
  localparam int AW2    = PADW + MASS_W;
  localparam int AW4    = PADW + K_W + 1;
  localparam int DW     = SW + K_W + 1 - ROUND_SHIFT;
  localparam int EW     = ((VW > DW) ? VW : DW) + 2;
  localparam int SIDE_W = 4 + 4 * VW + 2 * K_W;
  localparam int PPW    = CHUNK_W + K_W;

  logic en;

  assign en    = !(out_valid && out_stall);
  assign q_pop = en && q_avail;

  // unpack queue item
  logic                i_go, i_p2;
  logic [VW-1:0]       i_v1x, i_v1y, i_v2x, i_v2y;
  logic [NORM_W-1:0]   i_nx, i_ny;
  logic [MASS_W-1:0]   i_m1, i_m2;
  logic [SW-1:0]       i_sum;
  logic [TOTAL_W-1:0]  i_total;

  assign {i_go, i_p2, i_v1x, i_v1y, i_v2x, i_v2y, i_nx, i_ny,
          i_m1, i_m2, i_sum, i_total} = q_data;

  logic [COEF_W-1:0] coef;
  logic [NORM_W-1:0] nmag_x, nmag_y;

  assign coef   = COEF_ONE + {1'b0, rest_coef};
  assign nmag_x = i_nx[NORM_W-1] ? (~i_nx + 1'b1) : i_nx;
  assign nmag_y = i_ny[NORM_W-1] ? (~i_ny + 1'b1) : i_ny;

  // B0: magnitude of separating velocity, restitution times normal
  logic               b0_v, b0_go, b0_p2, b0_nneg_x, b0_nneg_y;
  logic [VW-1:0]      b0_v1x, b0_v1y, b0_v2x, b0_v2y;
  logic [K_W-1:0]     b0_kx, b0_ky;
  logic [MASS_W-1:0]  b0_m1, b0_m2;
  logic [TOTAL_W-1:0] b0_total;
  logic [SW-1:0]      b0_s;
  logic [PADW-1:0]    b0_s_pad;

  assign b0_s_pad = PADW'(b0_s);

  // B1: partial products of s times each inverse mass
  logic                 b1_v;
  logic [2*CHUNK_W-1:0] b1_pp_a [NC];
  logic [2*CHUNK_W-1:0] b1_pp_b [NC];
  logic [TOTAL_W-1:0]   b1_total;
  logic [SIDE_W-1:0]    b1_side;

  // B2: numerators
  logic               b2_v;
  logic [NW-1:0]      b2_num_a, b2_num_b;
  logic [TOTAL_W-1:0] b2_total;
  logic [SIDE_W-1:0]  b2_side;
  logic [AW2-1:0]     acc_a, acc_b;

  always_comb begin
    acc_a = '0;
    acc_b = '0;
    for (int i = 0; i < NC; i++) begin
      acc_a = acc_a + (AW2'(b1_pp_a[i]) << (CHUNK_W * i));
      acc_b = acc_b + (AW2'(b1_pp_b[i]) << (CHUNK_W * i));
    end
  end

  // divider
  logic              dv_v;
  logic [SW-1:0]     dv_qa, dv_qb;
  logic [SIDE_W-1:0] dv_side;

  cir_divider #(
    .QW     (SW),
    .DW     (TOTAL_W),
    .SIDE_W (SIDE_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b2_v),
    .num_a     (b2_num_a),
    .num_b     (b2_num_b),
    .den       (b2_total),
    .side_in   (b2_side),
    .out_valid (dv_v),
    .q_a       (dv_qa),
    .q_b       (dv_qb),
    .side_out  (dv_side)
  );

  logic           s_go, s_p2, s_nneg_x, s_nneg_y;
  logic [VW-1:0]  s_v1x, s_v1y, s_v2x, s_v2y;
  logic [K_W-1:0] s_kx, s_ky;
  logic [PADW-1:0] q_pad [2];
  logic [K_W-1:0]  k_c   [2];
  logic            nneg  [2];

  assign {s_go, s_p2, s_nneg_x, s_nneg_y, s_v1x, s_v1y, s_v2x, s_v2y,
          s_kx, s_ky} = dv_side;
  assign q_pad[0] = PADW'(dv_qa);
  assign q_pad[1] = PADW'(dv_qb);
  assign k_c[0]   = s_kx;
  assign k_c[1]   = s_ky;
  assign nneg[0]  = s_nneg_x;
  assign nneg[1]  = s_nneg_y;

  // B3: partial products of quotient times coefficient
  logic           b3_v, b3_go, b3_p2;
  logic [PPW-1:0] b3_pp  [2][2][NC];
  logic [VW-1:0]  b3_vel [2][2];
  logic           b3_neg [2][2];

  // B4: rounded velocity deltas
  logic           b4_v, b4_go, b4_p2;
  logic [DW-1:0]  b4_d   [2][2];
  logic [VW-1:0]  b4_vel [2][2];
  logic           b4_neg [2][2];
  logic [AW4-1:0] acc4   [2][2];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int c = 0; c < 2; c++) begin
        acc4[b][c] = AW4'(1) << (ROUND_SHIFT - 1);
        for (int i = 0; i < NC; i++) begin
          acc4[b][c] = acc4[b][c] + (AW4'(b3_pp[b][c][i]) << (CHUNK_W * i));
        end
      end
    end
  end

  // B5: apply and saturate
  logic [VW-1:0] res   [2][2];
  logic          sat_c [2][2];
  logic          any_sat;

  always_comb begin
    logic signed [EW-1:0] ve;
    logic signed [EW-1:0] de;
    logic signed [EW-1:0] r;
    logic [EW-VW:0]       hi;
    logic                 ovf;
    logic                 take;
    any_sat = 1'b0;
    for (int b = 0; b < 2; b++) begin
      for (int c = 0; c < 2; c++) begin
        ve   = {{(EW-VW){b4_vel[b][c][VW-1]}}, b4_vel[b][c]};
        de   = EW'(b4_d[b][c]);
        r    = b4_neg[b][c] ? (ve - de) : (ve + de);
        hi   = r[EW-1:VW-1];
        ovf  = !(&hi) && (|hi);
        take = b4_go && ((b == 0) || b4_p2);
        if (!take) begin
          res[b][c] = b4_vel[b][c];
        end else if (ovf) begin
          res[b][c] = r[EW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
          res[b][c] = r[VW-1:0];
        end
        sat_c[b][c] = take && ovf;
        any_sat     = any_sat | sat_c[b][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v      <= 1'b0;
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      b3_v      <= 1'b0;
      b4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b0_v      <= q_pop;
      b1_v      <= b0_v;
      b2_v      <= b1_v;
      b3_v      <= dv_v;
      b4_v      <= b3_v;
      out_valid <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_go     <= i_go;
      b0_p2     <= i_p2;
      b0_nneg_x <= i_nx[NORM_W-1];
      b0_nneg_y <= i_ny[NORM_W-1];
      b0_v1x    <= i_v1x;
      b0_v1y    <= i_v1y;
      b0_v2x    <= i_v2x;
      b0_v2y    <= i_v2y;
      b0_kx     <= coef * nmag_x;
      b0_ky     <= coef * nmag_y;
      b0_m1     <= i_m1;
      b0_m2     <= i_m2;
      b0_total  <= i_total;
      b0_s      <= ~i_sum + 1'b1;

      for (int i = 0; i < NC; i++) begin
        b1_pp_a[i] <= b0_s_pad[i*CHUNK_W +: CHUNK_W] * b0_m1;
        b1_pp_b[i] <= b0_s_pad[i*CHUNK_W +: CHUNK_W] * b0_m2;
      end
      b1_total <= b0_total;
      b1_side  <= {b0_go, b0_p2, b0_nneg_x, b0_nneg_y, b0_v1x, b0_v1y,
                   b0_v2x, b0_v2y, b0_kx, b0_ky};

      b2_num_a <= acc_a[NW-1:0];
      b2_num_b <= acc_b[NW-1:0];
      b2_total <= b1_total;
      b2_side  <= b1_side;

      b3_go <= s_go;
      b3_p2 <= s_p2;
      b3_vel[0][0] <= s_v1x;
      b3_vel[0][1] <= s_v1y;
      b3_vel[1][0] <= s_v2x;
      b3_vel[1][1] <= s_v2y;
      for (int c = 0; c < 2; c++) begin
        b3_neg[0][c] <= nneg[c];
        b3_neg[1][c] <= !nneg[c];
      end
      for (int b = 0; b < 2; b++) begin
        for (int c = 0; c < 2; c++) begin
          for (int i = 0; i < NC; i++) begin
            b3_pp[b][c][i] <= q_pad[b][i*CHUNK_W +: CHUNK_W] * k_c[c];
          end
        end
      end

      b4_go <= b3_go;
      b4_p2 <= b3_p2;
      for (int b = 0; b < 2; b++) begin
        for (int c = 0; c < 2; c++) begin
          b4_d[b][c]   <= acc4[b][c][SW+K_W:ROUND_SHIFT];
          b4_vel[b][c] <= b3_vel[b][c];
          b4_neg[b][c] <= b3_neg[b][c];
        end
      end

      new_first_vel_x  <= res[0][0];
      new_first_vel_y  <= res[0][1];
      new_second_vel_x <= res[1][0];
      new_second_vel_y <= res[1][1];
      impulse_applied  <= b4_go;
      saturated        <= any_sat;
    end
  end

  a_sat_needs_impulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && !impulse_applied |-> !saturated)
    else $error("saturation reported without impulse");

  a_pop_starts_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> b0_v)
    else $error("popped request lost at pipeline entry");

endmodule

>>> rtl/collision_impulse_resolver.sv
// ----------------------------------------------------------------------------
// collision_impulse_resolver: 2D contact impulse resolver
// Resolves one contact per request: separating velocity along the normal,
// impulse scaled by restitution and inverse masses, saturated velocities.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------
//   in      | in_valid / in_stall       | presence flags, velocities, normal,
//           |                           | inverse masses
//   out     | out_valid / out_stall     | new velocities, impulse_applied,
//           |                           | saturated
//   cfg     | cfg_valid / cfg_ready     | restitution (Q1.15)
//
// One request per cycle sustained while neither in_stall nor out_stall holds
// the flow. A request passes the front stages, the queue, the back stages
// B0 to B2, the one-bit-per-stage divider and B3 to B5. Synchronous reset
// empties the pipeline and loads restitution with 1.0. out_stall freezes the
// back pipeline; in_stall rises once the front and the queue hold
// QUEUE_DEPTH requests.
// ----------------------------------------------------------------------------
module collision_impulse_resolver #(
  parameter int VEL_WIDTH   = cir_pkg::VEL_WIDTH_DEF,
  parameter int QUEUE_DEPTH = cir_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              first_present,
  input  logic                              second_present,
  input  logic signed [VEL_WIDTH-1:0]       first_vel_x,
  input  logic signed [VEL_WIDTH-1:0]       first_vel_y,
  input  logic signed [VEL_WIDTH-1:0]       second_vel_x,
  input  logic signed [VEL_WIDTH-1:0]       second_vel_y,
  input  logic signed [cir_pkg::NORM_W-1:0] normal_x,
  input  logic signed [cir_pkg::NORM_W-1:0] normal_y,
  input  logic [cir_pkg::MASS_W-1:0]        first_inv_mass,
  input  logic [cir_pkg::MASS_W-1:0]        second_inv_mass,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [VEL_WIDTH-1:0]       new_first_vel_x,
  output logic signed [VEL_WIDTH-1:0]       new_first_vel_y,
  output logic signed [VEL_WIDTH-1:0]       new_second_vel_x,
  output logic signed [VEL_WIDTH-1:0]       new_second_vel_y,
  output logic                              impulse_applied,
  output logic                              saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cir_pkg::REST_W-1:0]        restitution
);
  import cir_pkg::*;

  localparam int IW    = item_w(VEL_WIDTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W = CNT_W + 1;

  logic [REST_W-1:0] rest_coef;
  logic              accept;
  logic              push;
  logic [IW-1:0]     item;
  logic [1:0]        inflight;
  logic              pop;
  logic [IW-1:0]     q_data;
  logic [CNT_W-1:0]  q_count;
  logic [OCC_W-1:0]  occ;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_coef <= REST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rest_coef <= restitution;
    end
  end

  assign occ      = OCC_W'(inflight) + OCC_W'(q_count);
  assign in_stall = occ >= OCC_W'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  cir_front #(
    .VEL_WIDTH (VEL_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .first_present   (first_present),
    .second_present  (second_present),
    .first_vel_x     (first_vel_x),
    .first_vel_y     (first_vel_y),
    .second_vel_x    (second_vel_x),
    .second_vel_y    (second_vel_y),
    .normal_x        (normal_x),
    .normal_y        (normal_y),
    .first_inv_mass  (first_inv_mass),
    .second_inv_mass (second_inv_mass),
    .push            (push),
    .item            (item),
    .inflight        (inflight)
  );

  cir_queue #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (item),
    .pop       (pop),
    .pop_data  (q_data),
    .count     (q_count)
  );

  cir_back #(
    .VEL_WIDTH (VEL_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_avail          (q_count != '0),
    .q_data           (q_data),
    .q_pop            (pop),
    .rest_coef        (rest_coef),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .new_first_vel_x  (new_first_vel_x),
    .new_first_vel_y  (new_first_vel_y),
    .new_second_vel_x (new_second_vel_x),
    .new_second_vel_y (new_second_vel_y),
    .impulse_applied  (impulse_applied),
    .saturated        (saturated)
  );

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("front and queue hold more requests than the queue depth");

endmodule
